// ===== src/sntu_pkg.sv =====
package sntu_pkg;

  // default sizes
  localparam int WEIGHT_COUNT_DEF = 1024;
  localparam int BATCH_SLOTS_DEF  = 128;

  // item kinds
  localparam logic [2:0] OP_FWD = 3'd0;
  localparam logic [2:0] OP_NRM = 3'd1;
  localparam logic [2:0] OP_ADD = 3'd2;
  localparam logic [2:0] OP_UPD = 3'd3;
  localparam logic [2:0] OP_PRT = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ACT  = 2'd0;
  localparam logic [1:0] KIND_PROB = 2'd1;
  localparam logic [1:0] KIND_BACK = 2'd2;
  localparam logic [1:0] KIND_WGT  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ADAM_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_LEARNING_RATE = 3'd1;
  localparam logic [2:0] CFG_BETA_ONE      = 3'd2;
  localparam logic [2:0] CFG_BETA_TWO      = 3'd3;
  localparam logic [2:0] CFG_EPSILON       = 3'd4;
  localparam logic [2:0] CFG_NODE_KIND     = 3'd5;
  localparam logic [2:0] CFG_NODE_ID       = 3'd6;

  localparam int CFG_DATA_W = 17;

  typedef struct packed {
    logic [2:0]         op;
    logic [6:0]         slot;
    logic [9:0]         index;
    logic signed [31:0] value;
    logic               last;
    logic [15:0]        label;
  } in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] result_value;
    logic [6:0]         result_slot;
  } out_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/sparse_neuron_train_unit.sv =====
// sparse_neuron_train_unit: one training neuron around a shared multiplier, a one-bit-per-cycle
// square root unit and a one-bit-per-cycle divider, one transaction in flight; an update term
// trains its weight (a plain step, or adam through the square root and divider), a last update term
// also trains the bias, and a term with no weight in range trains only the bias, and only if last;
// a result waiting in the output register holds the next result in S_EMIT, and so the input off.
// after reset a clearing pass of max(WEIGHT_COUNT, BATCH_SLOTS) entries zeroes all stores, in_ready low.
module sparse_neuron_train_unit #(
  parameter int WEIGHT_COUNT = sntu_pkg::WEIGHT_COUNT_DEF,
  parameter int BATCH_SLOTS  = sntu_pkg::BATCH_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sntu_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sntu_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [sntu_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sntu_pkg::*;

  localparam int WA    = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
  localparam int SA    = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
  localparam int CLR_N = (WEIGHT_COUNT > BATCH_SLOTS) ? WEIGHT_COUNT : BATCH_SLOTS;
  localparam int CW    = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_LOAD = 5'd2;
  localparam logic [4:0] S_FWD1 = 5'd3;
  localparam logic [4:0] S_FWD2 = 5'd4;
  localparam logic [4:0] S_NRM  = 5'd5;
  localparam logic [4:0] S_DIV  = 5'd6;
  localparam logic [4:0] S_NRM2 = 5'd7;
  localparam logic [4:0] S_ADD  = 5'd8;
  localparam logic [4:0] S_UPD1 = 5'd9;
  localparam logic [4:0] S_UPD2 = 5'd10;
  localparam logic [4:0] S_UPD3 = 5'd11;
  localparam logic [4:0] S_TR   = 5'd12;
  localparam logic [4:0] S_S2   = 5'd13;
  localparam logic [4:0] S_A2   = 5'd14;
  localparam logic [4:0] S_A3   = 5'd15;
  localparam logic [4:0] S_A4   = 5'd16;
  localparam logic [4:0] S_A5   = 5'd17;
  localparam logic [4:0] S_A6   = 5'd18;
  localparam logic [4:0] S_A7   = 5'd19;
  localparam logic [4:0] S_SQ   = 5'd20;
  localparam logic [4:0] S_DEN  = 5'd21;
  localparam logic [4:0] S_A8   = 5'd22;
  localparam logic [4:0] S_WB   = 5'd23;
  localparam logic [4:0] S_PRT  = 5'd24;
  localparam logic [4:0] S_EMIT = 5'd25;

  // configuration
  logic        adam_r;
  logic [16:0] lr_r;
  logic [15:0] b1_r, b2_r, eps_r;
  logic        kind_r;
  logic [15:0] node_id_r;

  // control
  logic [4:0]    state_r;
  logic [CW-1:0] clr_cnt_r;
  logic [5:0]    it_r;
  logic          out_valid_r;
  out_t          out_data_r;

  // item and loaded operands
  in_t                item_r;
  logic               widx_r, wslot_r;
  logic signed [31:0] w_r, m_r, v_r, act_r, dlt_r, g_r, res_r;
  logic signed [31:0] acc_r, bias_r, bias_m_r, bias_v_r;

  // training target
  logic               tgt_bias_r;
  logic signed [31:0] tw_r, tm_r, tv_r, tg_r, nm_r, nv_r, g2_r, t_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;
  logic signed [65:0] prod_fl;

  // divider
  logic [32:0] dv_rem_r, dv_den_r;
  logic [48:0] dv_num_r, dv_quo_r;
  logic        dv_neg_r, dv_zero_r;
  logic [33:0] dv_sh;
  logic [34:0] dv_diff;
  logic signed [31:0] q_val;

  // square root
  logic [47:0] sq_x_r;
  logic [25:0] sq_rem_r;
  logic [23:0] sq_root_r;
  logic [27:0] sq_sh, sq_trial;

  // memories
  logic signed [31:0] w_mem [WEIGHT_COUNT];
  logic signed [31:0] m_mem [WEIGHT_COUNT];
  logic signed [31:0] v_mem [WEIGHT_COUNT];
  logic signed [31:0] act_mem [BATCH_SLOTS];
  logic signed [31:0] dlt_mem [BATCH_SLOTS];
  logic signed [31:0] rd_w_r, rd_m_r, rd_v_r, rd_act_r, rd_dlt_r;

  logic               mem_we;
  logic [WA-1:0]      mem_addr;
  logic signed [31:0] wd_w, wd_m, wd_v;
  logic               slot_we;
  logic [SA-1:0]      slot_addr;
  logic signed [31:0] wd_act, wd_dlt;

  // forward finish values
  logic signed [31:0] fwd_term, fwd_res;
  logic               fwd_clip;

  // normalize and adam operand helpers
  logic signed [32:0] nrm_den, a7_num;
  logic [32:0]        nrm_den_abs, a7_abs;
  logic [31:0]        act_abs;
  logic [16:0]        omb1, omb2;
  logic               emit_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign emit_free = !out_valid_r || out_ready;

  assign omb1 = 17'h10000 - {1'b0, b1_r};
  assign omb2 = 17'h10000 - {1'b0, b2_r};
  assign prod_fl = prod_r >>> 16;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_FWD1: begin mul_a = 33'(w_r);   mul_b = 33'(item_r.value); end
      S_UPD1: begin mul_a = 33'(dlt_r); mul_b = 33'(item_r.value); end
      S_UPD2: begin mul_a = 33'(dlt_r); mul_b = 33'(w_r); end
      S_TR: begin
        mul_a = adam_r ? 33'(tg_r) : $signed({16'b0, lr_r});
        mul_b = 33'(tg_r);
      end
      S_A2: begin mul_a = $signed({17'b0, b1_r}); mul_b = 33'(tm_r); end
      S_A3: begin mul_a = $signed({16'b0, omb1}); mul_b = 33'(tg_r); end
      S_A4: begin mul_a = $signed({17'b0, b2_r}); mul_b = 33'(tv_r); end
      S_A5: begin mul_a = $signed({16'b0, omb2}); mul_b = 33'(g2_r); end
      S_A6: begin mul_a = $signed({16'b0, lr_r}); mul_b = 33'(nm_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider and square root steps
  assign dv_sh    = {dv_rem_r, dv_num_r[48]};
  assign dv_diff  = {1'b0, dv_sh} - {2'b0, dv_den_r};
  assign q_val    = dv_zero_r ? 32'sd0 :
                    sat32(dv_neg_r ? -$signed({17'b0, dv_quo_r}) : $signed({17'b0, dv_quo_r}));
  assign sq_sh    = {sq_rem_r, sq_x_r[47:46]};
  assign sq_trial = {2'b0, sq_root_r, 2'b01};

  // forward finish
  always_comb begin
    fwd_term = sat32(prod_fl);
    fwd_res  = sat32(66'(acc_r) + 66'(fwd_term) + 66'(bias_r));
    fwd_clip = !kind_r && fwd_res < 0;
  end

  // normalize and adam divider operands
  always_comb begin
    nrm_den     = 33'(item_r.value) + 33'sd1;
    nrm_den_abs = nrm_den[32] ? 33'(-nrm_den) : 33'(nrm_den);
    act_abs     = act_r[31] ? 32'(-act_r) : 32'(act_r);
    a7_num      = 33'(prod_fl);
    a7_abs      = a7_num[32] ? 33'(-a7_num) : 33'(a7_num);
  end

  // weight, moment and velocity store write port
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = WA'(item_r.index);
    wd_w     = tw_r;
    wd_m     = adam_r ? nm_r : tm_r;
    wd_v     = adam_r ? nv_r : tv_r;
    unique case (state_r)
      S_CLR: begin
        mem_we   = (32'(clr_cnt_r) < 32'(WEIGHT_COUNT));
        mem_addr = WA'(clr_cnt_r);
        wd_w = '0; wd_m = '0; wd_v = '0;
      end
      S_PRT: begin
        mem_we = widx_r;
        wd_w   = sat32(66'(w_r) + 66'(item_r.value));
        wd_m   = m_r;
        wd_v   = v_r;
      end
      S_WB: mem_we = !tgt_bias_r;
      default: mem_we = 1'b0;
    endcase
  end

  // slot store write port
  always_comb begin
    slot_we   = 1'b0;
    slot_addr = SA'(item_r.slot);
    wd_act    = '0;
    wd_dlt    = '0;
    unique case (state_r)
      S_CLR: begin
        slot_we   = (32'(clr_cnt_r) < 32'(BATCH_SLOTS));
        slot_addr = SA'(clr_cnt_r);
      end
      S_FWD2: begin
        slot_we = wslot_r && item_r.last;
        wd_act  = fwd_clip ? 32'sd0 : fwd_res;
        wd_dlt  = fwd_clip ? 32'sd0 : dlt_r;
      end
      S_NRM2: begin
        slot_we = wslot_r;
        wd_act  = q_val;
        wd_dlt  = (node_id_r == item_r.label) ? sat32(66'sd65536 - 66'(q_val))
                                              : sat32(-66'(q_val));
      end
      S_ADD: begin
        slot_we = wslot_r && act_r > 0;
        wd_act  = act_r;
        wd_dlt  = sat32(66'(dlt_r) + 66'(item_r.value));
      end
      S_UPD3: slot_we = wslot_r && item_r.last;
      default: slot_we = 1'b0;
    endcase
  end

  // memories, read at the incoming transaction's addresses
  always_ff @(posedge clk) begin
    if (mem_we) begin
      w_mem[mem_addr] <= wd_w;
      m_mem[mem_addr] <= wd_m;
      v_mem[mem_addr] <= wd_v;
    end
    rd_w_r <= w_mem[WA'(in_data.index)];
    rd_m_r <= m_mem[WA'(in_data.index)];
    rd_v_r <= v_mem[WA'(in_data.index)];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      act_mem[slot_addr] <= wd_act;
      dlt_mem[slot_addr] <= wd_dlt;
    end
    rd_act_r <= act_mem[SA'(in_data.slot)];
    rd_dlt_r <= dlt_mem[SA'(in_data.slot)];
  end

  // multiplier register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adam_r    <= 1'b0;
      lr_r      <= 17'd66;
      b1_r      <= 16'd58982;
      b2_r      <= 16'd65470;
      eps_r     <= 16'd1;
      kind_r    <= 1'b0;
      node_id_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADAM_ENABLE:   adam_r    <= cfg_wdata[0];
        CFG_LEARNING_RATE: lr_r      <= cfg_wdata;
        CFG_BETA_ONE:      b1_r      <= cfg_wdata[15:0];
        CFG_BETA_TWO:      b2_r      <= cfg_wdata[15:0];
        CFG_EPSILON:       eps_r     <= cfg_wdata[15:0];
        CFG_NODE_KIND:     kind_r    <= cfg_wdata[0];
        CFG_NODE_ID:       node_id_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      bias_r      <= '0;
      bias_m_r    <= '0;
      bias_v_r    <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        // zero every store entry
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (32'(clr_cnt_r) == CLR_N - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            widx_r  <= (32'(in_data.index) < 32'(WEIGHT_COUNT));
            wslot_r <= (32'(in_data.slot) < 32'(BATCH_SLOTS));
            state_r <= S_LOAD;
          end
        end
        // gate out of range reads and dispatch
        S_LOAD: begin
          w_r   <= widx_r ? rd_w_r : 32'sd0;
          m_r   <= widx_r ? rd_m_r : 32'sd0;
          v_r   <= widx_r ? rd_v_r : 32'sd0;
          act_r <= wslot_r ? rd_act_r : 32'sd0;
          dlt_r <= wslot_r ? rd_dlt_r : 32'sd0;
          unique case (item_r.op)
            OP_FWD:  state_r <= S_FWD1;
            OP_NRM:  state_r <= S_NRM;
            OP_ADD:  state_r <= S_ADD;
            OP_UPD:  state_r <= S_UPD1;
            OP_PRT:  state_r <= S_PRT;
            default: state_r <= S_IDLE;
          endcase
        end
        S_FWD1: state_r <= S_FWD2;
        S_FWD2: begin
          if (!item_r.last) begin
            acc_r   <= sat32(66'(acc_r) + 66'(fwd_term));
            state_r <= S_IDLE;
          end else begin
            acc_r   <= '0;
            res_r   <= fwd_clip ? 32'sd0 : fwd_res;
            state_r <= S_EMIT;
          end
        end
        // load the divider with activation over norm
        S_NRM: begin
          dv_num_r  <= {1'b0, act_abs, 16'b0};
          dv_den_r  <= nrm_den_abs;
          dv_neg_r  <= act_r[31] ^ nrm_den[32];
          dv_zero_r <= (act_r == 0);
          dv_rem_r  <= '0;
          dv_quo_r  <= '0;
          it_r      <= 6'd48;
          state_r   <= S_DIV;
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          dv_num_r <= {dv_num_r[47:0], 1'b0};
          if (!dv_diff[34]) begin
            dv_rem_r <= dv_diff[32:0];
            dv_quo_r <= {dv_quo_r[47:0], 1'b1};
          end else begin
            dv_rem_r <= dv_sh[32:0];
            dv_quo_r <= {dv_quo_r[47:0], 1'b0};
          end
          it_r <= it_r - 1'b1;
          if (it_r == 6'd0) state_r <= (item_r.op == OP_NRM) ? S_NRM2 : S_A8;
        end
        S_NRM2: begin
          res_r   <= q_val;
          state_r <= S_EMIT;
        end
        S_ADD: state_r <= S_IDLE;
        // gradient and back delta term
        S_UPD1: state_r <= S_UPD2;
        S_UPD2: begin
          g_r     <= sat32(prod_fl);
          state_r <= S_UPD3;
        end
        S_UPD3: begin
          res_r <= sat32(prod_fl);
          if (widx_r) begin
            tgt_bias_r <= 1'b0;
            tw_r <= w_r; tm_r <= m_r; tv_r <= v_r; tg_r <= g_r;
            state_r <= S_TR;
          end else if (item_r.last) begin
            tgt_bias_r <= 1'b1;
            tw_r <= bias_r; tm_r <= bias_m_r; tv_r <= bias_v_r; tg_r <= dlt_r;
            state_r <= S_TR;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_TR: state_r <= adam_r ? S_A2 : S_S2;
        // plain gradient step
        S_S2: begin
          tw_r    <= sat32(66'(tw_r) + prod_fl);
          state_r <= S_WB;
        end
        // adam moments
        S_A2: begin
          g2_r    <= sat32(prod_fl);
          state_r <= S_A3;
        end
        S_A3: begin
          t_r     <= 32'(prod_fl);
          state_r <= S_A4;
        end
        S_A4: begin
          nm_r    <= sat32(66'(t_r) + prod_fl);
          state_r <= S_A5;
        end
        S_A5: begin
          t_r     <= 32'(prod_fl);
          state_r <= S_A6;
        end
        S_A6: begin
          nv_r    <= sat32(66'(t_r) + prod_fl);
          state_r <= S_A7;
        end
        // step numerator into the divider, velocity into the square root
        S_A7: begin
          dv_num_r  <= {a7_abs, 16'b0};
          dv_neg_r  <= a7_num[32];
          dv_zero_r <= (a7_num == 0);
          sq_x_r    <= nv_r[31] ? 48'd0 : {1'b0, nv_r[30:0], 16'b0};
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          it_r      <= 6'd23;
          state_r   <= S_SQ;
        end
        // digit by digit square root, one root bit a cycle
        S_SQ: begin
          sq_x_r <= {sq_x_r[45:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            sq_rem_r  <= 26'(sq_sh - sq_trial);
            sq_root_r <= {sq_root_r[22:0], 1'b1};
          end else begin
            sq_rem_r  <= sq_sh[25:0];
            sq_root_r <= {sq_root_r[22:0], 1'b0};
          end
          it_r <= it_r - 1'b1;
          if (it_r == 6'd0) state_r <= S_DEN;
        end
        S_DEN: begin
          dv_den_r <= {9'b0, sq_root_r} + {17'b0, eps_r};
          dv_rem_r <= '0;
          dv_quo_r <= '0;
          it_r     <= 6'd48;
          state_r  <= S_DIV;
        end
        S_A8: begin
          tw_r    <= sat32(66'(tw_r) + 66'(q_val));
          state_r <= S_WB;
        end
        // write back the trained value, then the bias on a last term
        S_WB: begin
          if (tgt_bias_r) begin
            bias_r   <= tw_r;
            bias_m_r <= adam_r ? nm_r : tm_r;
            bias_v_r <= adam_r ? nv_r : tv_r;
            state_r  <= S_EMIT;
          end else if (item_r.last) begin
            tgt_bias_r <= 1'b1;
            tw_r <= bias_r; tm_r <= bias_m_r; tv_r <= bias_v_r; tg_r <= dlt_r;
            state_r <= S_TR;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_PRT: begin
          res_r   <= widx_r ? sat32(66'(w_r) + 66'(item_r.value)) : 32'sd0;
          state_r <= S_EMIT;
        end
        // hand the result to the output register
        S_EMIT: begin
          if (emit_free) begin
            out_valid_r               <= 1'b1;
            out_data_r.result_value   <= res_r;
            out_data_r.result_slot    <= (item_r.op == OP_PRT) ? 7'd0 : item_r.slot;
            unique case (item_r.op)
              OP_FWD:  out_data_r.result_kind <= KIND_ACT;
              OP_NRM:  out_data_r.result_kind <= KIND_PROB;
              OP_UPD:  out_data_r.result_kind <= KIND_BACK;
              default: out_data_r.result_kind <= KIND_WGT;
            endcase
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
